// File: rtl/dzc_pkg.sv
package dzc_pkg;

   // Pixel coordinate and register widths are fixed by the command format.
   localparam int COORD_BITS = 12;
   localparam int STEP_BITS = 12;
   localparam int FRAC_BITS = 8;

   localparam int IN_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int OUT_DATA_W = ((8 * COORD_BITS + 1 + 7) / 8) * 8;
   localparam int KIND_BITS = 2;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [COORD_BITS-1:0] FRAME_W_RESET = COORD_BITS'(1280);
   localparam logic [COORD_BITS-1:0] FRAME_H_RESET = COORD_BITS'(720);
   localparam logic [STEP_BITS-1:0] ZOOM_STEP_RESET = STEP_BITS'(205);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_W = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_H = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZOOM_STEP = CSR_INDEX_BITS'(2);

   typedef enum logic [KIND_BITS-1:0] {
      REQ_ZOOM_IN = 2'd0,
      REQ_ZOOM_OUT = 2'd1,
      REQ_CROP_RECT = 2'd2,
      REQ_FULL_FRAME = 2'd3
   } req_kind_type;

endpackage

// File: rtl/dzc_ser_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
module dzc_ser_mul #(
   parameter int WIDTH = dzc_pkg::COORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDTH-1:0]     mcand,
   input  logic [WIDTH-1:0]     mplier,
   output logic                 done,
   output logic [2*WIDTH-1:0]   product
);

   localparam int CNT_W = $clog2(WIDTH);

   logic [2*WIDTH-1:0] acc_ff, acc_in;
   logic [2*WIDTH-1:0] mcand_ff, mcand_in;
   logic [WIDTH-1:0]   mplier_ff, mplier_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mcand_in = {{WIDTH{1'b0}}, mcand};
         mplier_in = mplier;
         cnt_in = CNT_W'(WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

// File: rtl/dzc_ser_div.sv
// Restoring divider, one quotient bit per cycle, most significant bit first.
// The numerator shifts out at the top of quo_ff while quotient bits enter below.
module dzc_ser_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = dzc_pkg::COORD_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff = {1'b0, trial} - {2'b00, den_ff};
   assign fits = ~diff[DEN_W+1];

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = CNT_W'(NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/digital_zoom_crop_window_core.sv
// Digital zoom crop window controller.
// The block keeps a crop window (offset and size in signed fixed point with FRAC_BITS
// fraction bits) over a video frame and updates it on each command item taken from
// the req_ channel: zoom in, zoom out, crop to a rectangle, or restore the full frame.
// Every command item produces exactly one result item on the rsp_ channel carrying
// the window in whole pixels, the cropped flag and the last requested rectangle.
// The frame size and the zoom step are written through the csr_ port; the user
// must write them only while the block is idle, as the block does not enforce it.
// A write changes only the register, never the current window.
// A full-frame restore or an empty rectangle goes from S_START straight to S_OUT;
// zoom in and zoom out first wait for the two 12-bit bit-serial multipliers (one
// bit per cycle), and a crop to rectangle whose aspect differs from the frame also
// waits for the bit-serial divider that fits the box to the frame aspect ratio
// (one quotient bit per cycle over 2*COORD_BITS+FRAC_BITS bits).
// One command is processed at a time; a new one is accepted the cycle after the
// previous result has been placed in the output register.
// While the receiver stalls, the result item stays in the output register and a
// following command still runs; its result waits until the register is free.
// A synchronous reset restores the full frame at 1280 x 720, the default zoom
// step and an empty comparison rectangle, and drops any pending result item.
module digital_zoom_crop_window_core #(
   parameter int FRAC_BITS = dzc_pkg::FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Command channel.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata, from bit 0 up: corner_a_x, corner_a_y, corner_b_x, corner_b_y.
   input  logic [dzc_pkg::IN_DATA_W-1:0]          req_tdata,
   // tuser: req_type.
   input  logic [dzc_pkg::KIND_BITS-1:0]          req_tuser,
   // Result channel.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata, from bit 0 up: crop_x, crop_y, crop_w, crop_h, is_cropped,
   // cmp_x, cmp_y, cmp_w, cmp_h, then zero padding.
   output logic [dzc_pkg::OUT_DATA_W-1:0]         rsp_tdata,
   // Register write port.
   input  logic                                   csr_wr_en,
   input  logic [dzc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dzc_pkg::COORD_BITS-1:0]         csr_wr_data
);

   localparam int CW = dzc_pkg::COORD_BITS;
   localparam int SW = dzc_pkg::STEP_BITS;
   localparam int WIN_W = CW + FRAC_BITS + 1;
   localparam int EXT_W = WIN_W + 2;
   localparam int PROD_W = 2 * CW;
   localparam int NUM_W = PROD_W + FRAC_BITS;
   localparam int PAD_W = dzc_pkg::OUT_DATA_W - 8 * CW - 1;
   localparam logic signed [WIN_W-1:0] WIN_MAX = {1'b0, {(WIN_W-1){1'b1}}};
   localparam logic signed [WIN_W-1:0] WIN_MIN = {1'b1, {(WIN_W-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_MUL,
      S_DIV,
      S_UPD1,
      S_UPD2,
      S_UPD3,
      S_OUT
   } state_type;

   // Saturate a widened sum back into the window range.
   function automatic logic signed [WIN_W-1:0] sat_win(input logic signed [EXT_W-1:0] v);
      if (v[EXT_W-1:WIN_W-1] == '0 || v[EXT_W-1:WIN_W-1] == '1) begin
         return v[WIN_W-1:0];
      end else if (v[EXT_W-1]) begin
         return WIN_MIN;
      end else begin
         return WIN_MAX;
      end
   endfunction

   function automatic logic signed [EXT_W-1:0] ext_s(input logic signed [WIN_W-1:0] v);
      return $signed({{(EXT_W-WIN_W){v[WIN_W-1]}}, v});
   endfunction

   function automatic logic signed [EXT_W-1:0] ext_u(input logic [CW+FRAC_BITS-1:0] v);
      return $signed({{(EXT_W-CW-FRAC_BITS){1'b0}}, v});
   endfunction

   // Whole-pixel part of a window value; negative values read as zero.
   function automatic logic [CW-1:0] int_part(input logic signed [WIN_W-1:0] v);
      if (v[WIN_W-1]) begin
         return '0;
      end
      return v[CW+FRAC_BITS-1:FRAC_BITS];
   endfunction

   state_type                 state_ff, state_in;
   dzc_pkg::req_kind_type     kind_ff, kind_in;
   logic [CW-1:0]             ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic [CW-1:0]             frame_w_ff, frame_w_in, frame_h_ff, frame_h_in;
   logic [SW-1:0]             step_ff, step_in;
   logic signed [WIN_W-1:0]   win_x_ff, win_x_in, win_y_ff, win_y_in;
   logic signed [WIN_W-1:0]   win_w_ff, win_w_in, win_h_ff, win_h_in;
   logic signed [WIN_W-1:0]   tmp_x_ff, tmp_x_in, tmp_y_ff, tmp_y_in;
   logic signed [WIN_W-1:0]   tmp_w_ff, tmp_w_in, tmp_h_ff, tmp_h_in;
   logic [CW-1:0]             mx_ff, mx_in, my_ff, my_in;
   logic                      cropped_ff, cropped_in, rect_ff, rect_in;
   logic [CW-1:0]             cmp_x_ff, cmp_x_in, cmp_y_ff, cmp_y_in;
   logic [CW-1:0]             cmp_w_ff, cmp_w_in, cmp_h_ff, cmp_h_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [dzc_pkg::OUT_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0]             rw, rh, mnx, mny;
   logic                      rect_empty;
   logic signed [WIN_W-1:0]   fw, fh, fw_q, fh_q, rw_q, rh_q;
   logic                      mul_start, mul0_done, mul1_done, mul_done;
   logic [CW-1:0]             mul0_a, mul0_b, mul1_a, mul1_b;
   logic [PROD_W-1:0]         prod0, prod1;
   logic [NUM_W-1:0]          fs_w_full, hs_w_full, fs_h_full, hs_h_full;
   logic [CW+FRAC_BITS-1:0]   fs_w, hs_w, fs_h, hs_h;
   logic                      wide, tall;
   logic                      div_start, div_done;
   logic [CW-1:0]             div_den;
   logic [NUM_W-1:0]          div_num, quo;
   logic signed [WIN_W-1:0]   nq, d_fit;
   logic                      d_pos;
   logic [CW-1:0]             m_fit;
   logic signed [CW:0]        x0, y0;
   logic                      zoom_in;
   logic signed [WIN_W-1:0]   base_x, base_y, base_w, base_h;
   logic signed [WIN_W-1:0]   z_x, z_y, z_w, z_h;
   logic                      over_x, over_y;
   logic signed [WIN_W-1:0]   clamp_x, clamp_y;
   logic                      rsp_take;

   // Requested rectangle from the latched corners.
   assign rw = (ax_ff > bx_ff) ? ax_ff - bx_ff : bx_ff - ax_ff;
   assign rh = (ay_ff > by_ff) ? ay_ff - by_ff : by_ff - ay_ff;
   assign mnx = (ax_ff < bx_ff) ? ax_ff : bx_ff;
   assign mny = (ay_ff < by_ff) ? ay_ff : by_ff;
   assign rect_empty = (rw == '0) || (rh == '0);

   assign fw = $signed({1'b0, frame_w_ff, {FRAC_BITS{1'b0}}});
   assign fh = $signed({1'b0, frame_h_ff, {FRAC_BITS{1'b0}}});
   assign fw_q = $signed({3'b000, frame_w_ff, {(FRAC_BITS-2){1'b0}}});
   assign fh_q = $signed({3'b000, frame_h_ff, {(FRAC_BITS-2){1'b0}}});
   assign rw_q = $signed({1'b0, rw, {FRAC_BITS{1'b0}}});
   assign rh_q = $signed({1'b0, rh, {FRAC_BITS{1'b0}}});

   // Zoom needs frame size times step; the aspect test needs w*H and h*W.
   always_comb begin
      if (kind_ff == dzc_pkg::REQ_CROP_RECT) begin
         mul0_a = rw;
         mul0_b = frame_h_ff;
         mul1_a = rh;
         mul1_b = frame_w_ff;
      end else begin
         mul0_a = frame_w_ff;
         mul0_b = CW'(step_ff);
         mul1_a = frame_h_ff;
         mul1_b = CW'(step_ff);
      end
   end

   assign mul_start = (state_ff == S_START) &&
                      (kind_ff == dzc_pkg::REQ_ZOOM_IN || kind_ff == dzc_pkg::REQ_ZOOM_OUT ||
                       (kind_ff == dzc_pkg::REQ_CROP_RECT && !rect_empty));

   dzc_ser_mul #(.WIDTH(CW)) u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul0_a),
      .mplier  (mul0_b),
      .done    (mul0_done),
      .product (prod0)
   );

   dzc_ser_mul #(.WIDTH(CW)) u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul1_a),
      .mplier  (mul1_b),
      .done    (mul1_done),
      .product (prod1)
   );

   assign mul_done = mul0_done & mul1_done;

   // Step sizes: the step register is a fraction of 2**STEP_BITS.
   assign fs_w_full = {prod0, {FRAC_BITS{1'b0}}} >> SW;
   assign hs_w_full = {prod0, {FRAC_BITS{1'b0}}} >> (SW + 1);
   assign fs_h_full = {prod1, {FRAC_BITS{1'b0}}} >> SW;
   assign hs_h_full = {prod1, {FRAC_BITS{1'b0}}} >> (SW + 1);
   assign fs_w = fs_w_full[CW+FRAC_BITS-1:0];
   assign hs_w = hs_w_full[CW+FRAC_BITS-1:0];
   assign fs_h = fs_h_full[CW+FRAC_BITS-1:0];
   assign hs_h = hs_h_full[CW+FRAC_BITS-1:0];

   // Aspect fit: a wider box derives its height from the frame ratio, a taller
   // box its width.
   assign wide = prod0 > prod1;
   assign tall = prod1 > prod0;
   assign div_den = wide ? frame_w_ff : frame_h_ff;
   assign div_num = {(wide ? prod0 : prod1), {FRAC_BITS{1'b0}}};
   assign div_start = (state_ff == S_MUL) && mul_done &&
                      (kind_ff == dzc_pkg::REQ_CROP_RECT) && (wide || tall);

   dzc_ser_div #(.NUM_W(NUM_W), .DEN_W(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (div_den),
      .done     (div_done),
      .quotient (quo)
   );

   // A zero frame size or a quotient beyond the window range gives the largest value.
   assign nq = (div_den == '0 || quo[NUM_W-1:CW+FRAC_BITS] != '0) ? WIN_MAX :
               $signed({1'b0, quo[CW+FRAC_BITS-1:0]});
   assign d_fit = nq - (wide ? rh_q : rw_q);
   assign d_pos = !d_fit[WIN_W-1] && (d_fit != '0);
   assign m_fit = d_pos ? {1'b0, d_fit[WIN_W-2:FRAC_BITS+1]} : '0;

   assign x0 = $signed({1'b0, mnx}) - $signed({1'b0, mx_ff});
   assign y0 = $signed({1'b0, mny}) - $signed({1'b0, my_ff});

   // Zoom starts from the full frame when the last command was a rectangle.
   assign zoom_in = (kind_ff == dzc_pkg::REQ_ZOOM_IN);
   assign base_x = rect_ff ? '0 : win_x_ff;
   assign base_y = rect_ff ? '0 : win_y_ff;
   assign base_w = rect_ff ? fw : win_w_ff;
   assign base_h = rect_ff ? fh : win_h_ff;
   assign z_x = sat_win(zoom_in ? ext_s(base_x) + ext_u(hs_w) : ext_s(base_x) - ext_u(hs_w));
   assign z_y = sat_win(zoom_in ? ext_s(base_y) + ext_u(hs_h) : ext_s(base_y) - ext_u(hs_h));
   assign z_w = sat_win(zoom_in ? ext_s(base_w) - ext_u(fs_w) : ext_s(base_w) + ext_u(fs_w));
   assign z_h = sat_win(zoom_in ? ext_s(base_h) - ext_u(fs_h) : ext_s(base_h) + ext_u(fs_h));

   // Keep the fitted window inside the frame.
   assign over_x = (ext_s(win_x_ff) + ext_s(win_w_ff)) > ext_s(fw);
   assign over_y = (ext_s(win_y_ff) + ext_s(win_h_ff)) > ext_s(fh);
   assign clamp_x = sat_win(ext_s(fw) - ext_s(win_w_ff));
   assign clamp_y = sat_win(ext_s(fh) - ext_s(win_h_ff));

   assign rsp_take = rsp_valid_ff && rsp_tready;

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      bx_in = bx_ff;
      by_in = by_ff;
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      step_in = step_ff;
      win_x_in = win_x_ff;
      win_y_in = win_y_ff;
      win_w_in = win_w_ff;
      win_h_in = win_h_ff;
      tmp_x_in = tmp_x_ff;
      tmp_y_in = tmp_y_ff;
      tmp_w_in = tmp_w_ff;
      tmp_h_in = tmp_h_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      cropped_in = cropped_ff;
      rect_in = rect_ff;
      cmp_x_in = cmp_x_ff;
      cmp_y_in = cmp_y_ff;
      cmp_w_in = cmp_w_ff;
      cmp_h_in = cmp_h_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            dzc_pkg::CSR_FRAME_W: frame_w_in = csr_wr_data;
            dzc_pkg::CSR_FRAME_H: frame_h_in = csr_wr_data;
            dzc_pkg::CSR_ZOOM_STEP: step_in = SW'(csr_wr_data);
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = dzc_pkg::req_kind_type'(req_tuser);
               ax_in = req_tdata[CW-1:0];
               ay_in = req_tdata[2*CW-1:CW];
               bx_in = req_tdata[3*CW-1:2*CW];
               by_in = req_tdata[4*CW-1:3*CW];
               state_in = S_START;
            end
         end
         S_START: begin
            if (kind_ff == dzc_pkg::REQ_FULL_FRAME) begin
               win_x_in = '0;
               win_y_in = '0;
               win_w_in = fw;
               win_h_in = fh;
               cropped_in = 1'b0;
               rect_in = 1'b0;
               state_in = S_OUT;
            end else if (kind_ff == dzc_pkg::REQ_CROP_RECT && rect_empty) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               state_in = div_start ? S_DIV : S_UPD1;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_UPD1;
            end
         end
         S_UPD1: begin
            if (kind_ff == dzc_pkg::REQ_CROP_RECT) begin
               win_w_in = tall ? nq : rw_q;
               win_h_in = wide ? nq : rh_q;
               mx_in = tall ? m_fit : '0;
               my_in = wide ? m_fit : '0;
            end else begin
               win_x_in = base_x;
               win_y_in = base_y;
               win_w_in = base_w;
               win_h_in = base_h;
               tmp_x_in = z_x;
               tmp_y_in = z_y;
               tmp_w_in = z_w;
               tmp_h_in = z_h;
               cropped_in = 1'b1;
               rect_in = 1'b0;
            end
            state_in = S_UPD2;
         end
         S_UPD2: begin
            if (kind_ff == dzc_pkg::REQ_CROP_RECT) begin
               win_x_in = x0[CW] ? '0 : $signed({1'b0, x0[CW-1:0], {FRAC_BITS{1'b0}}});
               win_y_in = y0[CW] ? '0 : $signed({1'b0, y0[CW-1:0], {FRAC_BITS{1'b0}}});
               state_in = S_UPD3;
            end else begin
               if (zoom_in) begin
                  // Zoom in stops at a quarter of the frame size.
                  if (tmp_w_ff >= fw_q && tmp_h_ff >= fh_q) begin
                     win_x_in = tmp_x_ff;
                     win_y_in = tmp_y_ff;
                     win_w_in = tmp_w_ff;
                     win_h_in = tmp_h_ff;
                  end
               end else if (tmp_x_ff[WIN_W-1] || tmp_y_ff[WIN_W-1] ||
                            tmp_w_ff >= fw || tmp_h_ff >= fh) begin
                  // Zoomed out past the frame edge: back to the full frame.
                  win_x_in = '0;
                  win_y_in = '0;
                  win_w_in = fw;
                  win_h_in = fh;
                  cropped_in = 1'b0;
               end else begin
                  win_x_in = tmp_x_ff;
                  win_y_in = tmp_y_ff;
                  win_w_in = tmp_w_ff;
                  win_h_in = tmp_h_ff;
               end
               state_in = S_OUT;
            end
         end
         S_UPD3: begin
            if (over_x) begin
               win_x_in = clamp_x;
            end
            if (over_y) begin
               win_y_in = clamp_y;
            end
            cmp_x_in = mnx;
            cmp_y_in = mny;
            cmp_w_in = rw;
            cmp_h_in = rh;
            rect_in = 1'b1;
            cropped_in = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {{PAD_W{1'b0}}, cmp_h_ff, cmp_w_ff, cmp_y_ff, cmp_x_ff,
                              cropped_ff, int_part(win_h_ff), int_part(win_w_ff),
                              int_part(win_y_ff), int_part(win_x_ff)};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         frame_w_ff <= dzc_pkg::FRAME_W_RESET;
         frame_h_ff <= dzc_pkg::FRAME_H_RESET;
         step_ff <= dzc_pkg::ZOOM_STEP_RESET;
         win_x_ff <= '0;
         win_y_ff <= '0;
         win_w_ff <= $signed({1'b0, dzc_pkg::FRAME_W_RESET, {FRAC_BITS{1'b0}}});
         win_h_ff <= $signed({1'b0, dzc_pkg::FRAME_H_RESET, {FRAC_BITS{1'b0}}});
         cropped_ff <= 1'b0;
         rect_ff <= 1'b0;
         cmp_x_ff <= '0;
         cmp_y_ff <= '0;
         cmp_w_ff <= '0;
         cmp_h_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
         step_ff <= step_in;
         win_x_ff <= win_x_in;
         win_y_ff <= win_y_in;
         win_w_ff <= win_w_in;
         win_h_ff <= win_h_in;
         cropped_ff <= cropped_in;
         rect_ff <= rect_in;
         cmp_x_ff <= cmp_x_in;
         cmp_y_ff <= cmp_y_in;
         cmp_w_ff <= cmp_w_in;
         cmp_h_ff <= cmp_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
      tmp_x_ff <= tmp_x_in;
      tmp_y_ff <= tmp_y_in;
      tmp_w_ff <= tmp_w_in;
      tmp_h_ff <= tmp_h_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
